/* hw/rtl/t4t_pkg.sv */
// Shared types, codes and constants of the type 4 tag responder.
package t4t_pkg;

    typedef struct packed {
        logic [1:0]  operation;
        logic [9:0]  load_address;
        logic [7:0]  load_byte;
        logic [7:0]  class_byte;
        logic [7:0]  instruction;
        logic [7:0]  param_one;
        logic [7:0]  param_two;
        logic [7:0]  command_data_length;
        logic [15:0] file_id;
        logic [16:0] expected_length;
    } in_item_t;

    typedef struct packed {
        logic        is_status;
        logic [7:0]  data_byte;
        logic [1:0]  status_code;
        logic        final_piece;
        logic        whole_file_sent;
    } out_item_t;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_COMMAND = 2'd1;
    localparam logic [1:0] OP_SESSION = 2'd2;

    typedef enum logic [1:0] {
        SEL_NONE = 2'd0,
        SEL_CC   = 2'd1,
        SEL_NDEF = 2'd2
    } sel_t;

    typedef enum logic [1:0] {
        CODE_OK        = 2'd0,
        CODE_NOT_FOUND = 2'd1,
        CODE_FAIL      = 2'd2
    } code_t;

    localparam logic [7:0]  CLASS_ISO       = 8'h00;
    localparam logic [7:0]  INS_SELECT      = 8'hA4;
    localparam logic [7:0]  INS_READ        = 8'hB0;
    localparam logic [7:0]  SELECT_P1       = 8'h00;
    localparam logic [7:0]  SELECT_P2       = 8'h0C;
    localparam logic [7:0]  SELECT_DLEN     = 8'd2;
    localparam logic [15:0] FID_CC          = 16'hE103;
    localparam logic [15:0] FID_NDEF        = 16'hE104;
    localparam logic [7:0]  CC_LEN_HI_MASK  = 8'h7F;

    // File offsets and sizes: the largest file is a 2047-byte message plus its length.
    localparam int          FILE_W          = 12;
    localparam int          MSG_W           = 11;
    localparam logic [11:0] CC_SIZE         = 12'd15;
    localparam logic [11:0] NDEF_HDR_SIZE   = 12'd2;
    localparam logic [11:0] CC_LEN_HI_IDX   = 12'd11;
    localparam logic [11:0] CC_LEN_LO_IDX   = 12'd12;
    localparam logic [11:0] NDEF_LEN_HI_IDX = 12'd0;
    localparam logic [11:0] NDEF_LEN_LO_IDX = 12'd1;
    localparam int          LOAD_SPAN       = 1024;

    function automatic logic [7:0] cc_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h00;
            4'd1:    b = 8'h0F;
            4'd2:    b = 8'h20;
            4'd3:    b = 8'hFF;
            4'd4:    b = 8'hFF;
            4'd5:    b = 8'hFF;
            4'd6:    b = 8'hFF;
            4'd7:    b = 8'h04;
            4'd8:    b = 8'h06;
            4'd9:    b = 8'hE1;
            4'd10:   b = 8'h04;
            4'd11:   b = 8'hFF;
            4'd12:   b = 8'hFE;
            4'd13:   b = 8'h00;
            4'd14:   b = 8'hFF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CLAMP,
        S_DATA,
        S_STATUS
    } ctl_state_t;

    typedef struct packed {
        logic load;
        logic session_clear;
        logic capture;
        logic eval;
        logic clamp;
        logic emit_data;
        logic emit_status;
    } ctl_cmd_t;

    typedef struct packed {
        logic go_read;
        logic last_byte;
        logic out_free;
    } dp_sts_t;

endpackage

/* hw/rtl/t4t_if.sv */
// Valid/ready channel interfaces for request and response transactions.
interface t4t_req_if;
    logic              valid;
    logic              ready;
    t4t_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface t4t_rsp_if;
    logic               valid;
    logic               ready;
    t4t_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/type4_tag_apdu_responder_core.sv */
// Top level of the type 4 tag responder: controller, datapath and channel ports.
//
//  Port       Direction  Content
//  req        sink       load, command or session transaction, one item each
//  rsp        source     data byte or status result, final_piece on the status
//  cfg_we     in         write strobe of the ndef_length register
//  cfg_wdata  in         ndef_length value
//
// Load and session items keep the controller idle. A select or failing command
// runs eval then status; a read with data runs eval, clamp, data and status, one
// byte per cycle while rsp takes them, from the store's registered read port.
// Reset clears the selection, ndef_length and the output valid flag; the store is
// not cleared. A stalled rsp holds the state machine until the result is taken.
module type4_tag_apdu_responder_core #(
    parameter int NDEF_CAPACITY      = 1024,
    parameter int MAX_RESPONSE_BYTES = 63
) (
    input  logic                      clk,
    input  logic                      rst_n,
    t4t_req_if.sink                   req,
    t4t_rsp_if.source                 rsp,
    input  logic                      cfg_we,
    input  logic [t4t_pkg::MSG_W-1:0] cfg_wdata
);

    t4t_pkg::ctl_cmd_t ctl_cmd;
    t4t_pkg::dp_sts_t  dp_sts;

    t4t_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (req.payload.operation),
        .in_ready (req.ready),
        .sts      (dp_sts),
        .cmd      (ctl_cmd)
    );

    t4t_datapath #(
        .NDEF_CAPACITY      (NDEF_CAPACITY),
        .MAX_RESPONSE_BYTES (MAX_RESPONSE_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (req.payload),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (ctl_cmd),
        .sts       (dp_sts),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_item  (rsp.payload)
    );

    // A result is only loaded when the output register is free.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_cmd.emit_data || ctl_cmd.emit_status) |-> dp_sts.out_free)
        else $error("Result loaded while the output register was occupied.");

    // A command transaction closes the request side until its status is out.
    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.payload.operation == t4t_pkg::OP_COMMAND))
        |=> !req.ready)
        else $error("Request accepted while a command was still in progress.");

    // A status load shows up as the final result of the run.
    a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.emit_status |=> (rsp.valid && rsp.payload.is_status &&
                                 rsp.payload.final_piece))
        else $error("Status result missing its final marker.");

endmodule

/* hw/rtl/t4t_ctrl.sv */
// Controller state machine: load and session strobes, decode, read setup and result emission.
module t4t_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_op,
    output logic              in_ready,
    input  t4t_pkg::dp_sts_t  sts,
    output t4t_pkg::ctl_cmd_t cmd
);

    t4t_pkg::ctl_state_t state_reg;
    t4t_pkg::ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= t4t_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            t4t_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (in_op)
                        t4t_pkg::OP_LOAD:    cmd.load = 1'b1;
                        t4t_pkg::OP_SESSION: cmd.session_clear = 1'b1;
                        t4t_pkg::OP_COMMAND:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = t4t_pkg::S_EVAL;
                        end
                        default: ;
                    endcase
                end
            end
            t4t_pkg::S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.go_read ? t4t_pkg::S_CLAMP : t4t_pkg::S_STATUS;
            end
            t4t_pkg::S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = t4t_pkg::S_DATA;
            end
            t4t_pkg::S_DATA:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_data = 1'b1;
                    if (sts.last_byte)
                    begin
                        state_next = t4t_pkg::S_STATUS;
                    end
                end
            end
            t4t_pkg::S_STATUS:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_status = 1'b1;
                    state_next      = t4t_pkg::S_IDLE;
                end
            end
            default: state_next = t4t_pkg::S_IDLE;
        endcase
    end

endmodule

/* hw/rtl/t4t_datapath.sv */
// Datapath with the message store, file selection, read pointer and output register.
module t4t_datapath #(
    parameter int NDEF_CAPACITY      = 1024,
    parameter int MAX_RESPONSE_BYTES = 63
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  t4t_pkg::in_item_t                 in_item,
    input  logic                              cfg_we,
    input  logic [t4t_pkg::MSG_W-1:0]         cfg_wdata,
    input  t4t_pkg::ctl_cmd_t                 cmd,
    output t4t_pkg::dp_sts_t                  sts,
    output logic                              out_valid,
    input  logic                              out_ready,
    output t4t_pkg::out_item_t                out_item
);

    localparam int FW          = t4t_pkg::FILE_W;
    localparam int STORE_DEPTH = (NDEF_CAPACITY < t4t_pkg::LOAD_SPAN) ?
                                 NDEF_CAPACITY : t4t_pkg::LOAD_SPAN;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int CW          = $clog2(MAX_RESPONSE_BYTES + 1);
    localparam logic [FW-1:0] MAX_RESP = FW'(MAX_RESPONSE_BYTES);

    logic [7:0]                  mem [STORE_DEPTH];
    logic [7:0]                  rd_data_reg;
    t4t_pkg::in_item_t           item_reg;
    t4t_pkg::sel_t               sel_reg;
    logic [t4t_pkg::MSG_W-1:0]   ndef_len_reg;
    logic [FW-1:0]               rem_reg;
    logic [FW-1:0]               ptr_reg;
    logic [FW-1:0]               ptr_next;
    logic [CW-1:0]               cnt_reg;
    logic [1:0]                  code_reg;
    logic                        whole_reg;
    logic                        out_valid_reg;
    t4t_pkg::out_item_t          out_reg;

    logic [t4t_pkg::MSG_W-1:0]   msg_len;
    logic [FW-1:0]               total;
    logic [FW-1:0]               size;
    logic [14:0]                 offset;
    logic                        is_select;
    logic                        is_read;
    logic                        read_bad;
    logic                        past_end;
    logic                        go_read;
    logic                        sel_ok;
    logic                        fid_cc;
    logic                        fid_ndef;
    logic                        sel_apply;
    t4t_pkg::sel_t               sel_target;
    t4t_pkg::code_t              eval_code;
    logic [FW-1:0]               clamp_le;
    logic [FW-1:0]               clamp_cnt;
    logic [7:0]                  file_byte;
    logic                        out_free;
    logic                        mem_we;

    assign msg_len = (32'(ndef_len_reg) > 32'(NDEF_CAPACITY)) ?
                     t4t_pkg::MSG_W'(NDEF_CAPACITY) : ndef_len_reg;
    assign total   = FW'(msg_len) + t4t_pkg::NDEF_HDR_SIZE;
    assign size    = (sel_reg == t4t_pkg::SEL_CC) ? t4t_pkg::CC_SIZE : total;
    assign offset  = {item_reg.param_one[6:0], item_reg.param_two};

    // Command decode, evaluated in the cycle after a command is captured.
    always_comb
    begin
        is_select  = (item_reg.class_byte == t4t_pkg::CLASS_ISO) &&
                     (item_reg.instruction == t4t_pkg::INS_SELECT);
        is_read    = (item_reg.class_byte == t4t_pkg::CLASS_ISO) &&
                     (item_reg.instruction == t4t_pkg::INS_READ);
        sel_ok     = (item_reg.param_one == t4t_pkg::SELECT_P1) &&
                     (item_reg.param_two == t4t_pkg::SELECT_P2);
        fid_ndef   = (item_reg.command_data_length == t4t_pkg::SELECT_DLEN) &&
                     (item_reg.file_id == t4t_pkg::FID_NDEF);
        fid_cc     = (item_reg.command_data_length == t4t_pkg::SELECT_DLEN) &&
                     (item_reg.file_id == t4t_pkg::FID_CC);
        read_bad   = item_reg.param_one[7] ||
                     ((sel_reg != t4t_pkg::SEL_CC) && (sel_reg != t4t_pkg::SEL_NDEF));
        past_end   = offset >= 15'(size);
        sel_apply  = is_select && sel_ok && (fid_ndef || fid_cc);
        sel_target = fid_ndef ? t4t_pkg::SEL_NDEF : t4t_pkg::SEL_CC;
        if (is_select)
        begin
            if (!sel_ok)
            begin
                eval_code = t4t_pkg::CODE_FAIL;
            end
            else if (fid_ndef || fid_cc)
            begin
                eval_code = t4t_pkg::CODE_OK;
            end
            else
            begin
                eval_code = t4t_pkg::CODE_NOT_FOUND;
            end
        end
        else if (is_read && !read_bad)
        begin
            eval_code = t4t_pkg::CODE_OK;
        end
        else
        begin
            eval_code = t4t_pkg::CODE_FAIL;
        end
        go_read = is_read && !read_bad && !past_end;
    end

    assign sts.go_read = go_read;

    always_comb
    begin
        if ((item_reg.expected_length != 17'd0) && (17'(rem_reg) > item_reg.expected_length))
        begin
            clamp_le = item_reg.expected_length[FW-1:0];
        end
        else
        begin
            clamp_le = rem_reg;
        end
        clamp_cnt = (clamp_le > MAX_RESP) ? MAX_RESP : clamp_le;
    end

    always_comb
    begin
        if (sel_reg == t4t_pkg::SEL_CC)
        begin
            if (ptr_reg == t4t_pkg::CC_LEN_HI_IDX)
            begin
                file_byte = 8'(total >> 8) & t4t_pkg::CC_LEN_HI_MASK;
            end
            else if (ptr_reg == t4t_pkg::CC_LEN_LO_IDX)
            begin
                file_byte = total[7:0];
            end
            else
            begin
                file_byte = t4t_pkg::cc_byte(ptr_reg[3:0]);
            end
        end
        else if (ptr_reg == t4t_pkg::NDEF_LEN_HI_IDX)
        begin
            file_byte = 8'(msg_len >> 8);
        end
        else if (ptr_reg == t4t_pkg::NDEF_LEN_LO_IDX)
        begin
            file_byte = msg_len[7:0];
        end
        else
        begin
            file_byte = rd_data_reg;
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.eval && sts.go_read)
        begin
            ptr_next = offset[FW-1:0];
        end
        else if (cmd.emit_data)
        begin
            ptr_next = ptr_reg + FW'(1);
        end
    end

    assign mem_we = cmd.load && (32'(in_item.load_address) < 32'(NDEF_CAPACITY));

    // The read address follows the next pointer, so the read data always matches ptr_reg.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[in_item.load_address[AW-1:0]] <= in_item.load_byte;
        end
        rd_data_reg <= mem[AW'(ptr_next - t4t_pkg::NDEF_HDR_SIZE)];
    end

    assign out_free      = !out_valid_reg || out_ready;
    assign sts.out_free  = out_free;
    assign sts.last_byte = cnt_reg == CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= t4t_pkg::SEL_NONE;
            ndef_len_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ndef_len_reg <= cfg_wdata;
            end
            if (cmd.session_clear)
            begin
                sel_reg <= t4t_pkg::SEL_NONE;
            end
            else if (cmd.eval && sel_apply)
            begin
                sel_reg <= sel_target;
            end
            if (cmd.emit_data || cmd.emit_status)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.capture)
        begin
            item_reg <= in_item;
        end
        if (cmd.eval)
        begin
            code_reg  <= eval_code;
            whole_reg <= 1'b0;
            rem_reg   <= size - offset[FW-1:0];
        end
        if (cmd.clamp)
        begin
            cnt_reg   <= CW'(clamp_cnt);
            whole_reg <= (sel_reg == t4t_pkg::SEL_NDEF) && (clamp_cnt == rem_reg);
        end
        if (cmd.emit_data)
        begin
            cnt_reg                 <= cnt_reg - CW'(1);
            out_reg.is_status       <= 1'b0;
            out_reg.data_byte       <= file_byte;
            out_reg.status_code     <= t4t_pkg::CODE_OK;
            out_reg.final_piece     <= 1'b0;
            out_reg.whole_file_sent <= whole_reg;
        end
        else if (cmd.emit_status)
        begin
            out_reg.is_status       <= 1'b1;
            out_reg.data_byte       <= 8'h00;
            out_reg.status_code     <= code_reg;
            out_reg.final_piece     <= 1'b1;
            out_reg.whole_file_sent <= whole_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

/* bench/type4_tag_apdu_responder_core_test.sv */
// Self-checking testbench of the type 4 tag responder core: predicts each reply and compares.
`timescale 1ns / 1ps

module type4_tag_apdu_responder_core_test;

    localparam int          STORE_DEPTH   = 1024;
    localparam int          REPLY_CAP     = 63;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          ERROR_REPORTS = 10;
    localparam int          HEAD_LOADS    = 80;
    localparam int          TAIL_LOADS    = 80;
    localparam int          PHASE_ITEMS   = 37;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;

    class tag_reply_board;
        t4t_pkg::sel_t      open_file;
        logic [10:0]        length_reg;
        logic [7:0]         msg_bytes [STORE_DEPTH];
        bit                 written [STORE_DEPTH];
        logic [7:0]         cc_image [15];
        t4t_pkg::out_item_t due_replies [$];
        int                 failures;

        function new();
            open_file  = t4t_pkg::SEL_NONE;
            length_reg = '0;
            failures   = 0;
            cc_image   = '{8'h00, 8'h0F, 8'h20, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h04,
                           8'h06, 8'hE1, 8'h04, 8'hFF, 8'hFE, 8'h00, 8'hFF};
        endfunction

        function int unsigned msg_length();
            int unsigned n;
            n = {21'd0, length_reg};
            if (n > STORE_DEPTH)
                n = STORE_DEPTH;
            return n;
        endfunction

        function logic [7:0] file_at(t4t_pkg::sel_t f, int unsigned idx);
            int unsigned n;
            int unsigned total;
            n = msg_length();
            total = n + 2;
            if (f == t4t_pkg::SEL_CC)
            begin
                if (idx == 11)
                    return 8'(total >> 8) & t4t_pkg::CC_LEN_HI_MASK;
                if (idx == 12)
                    return 8'(total);
                return cc_image[idx];
            end
            if (idx == 0)
                return 8'(n >> 8);
            if (idx == 1)
                return 8'(n);
            return msg_bytes[idx - 2];
        endfunction

        // A read is safe when every message byte it can return has been loaded.
        function bit read_is_safe(logic [15:0] off, logic [16:0] limit);
            int unsigned start;
            int unsigned size;
            int unsigned count;
            if (off[15])
                return 1'b1;
            start = {17'd0, off[14:0]};
            size  = msg_length() + 2;
            if (start >= size)
                return 1'b1;
            count = size - start;
            if (limit != 0 && count > limit)
                count = {15'd0, limit};
            if (count > REPLY_CAP)
                count = REPLY_CAP;
            for (int unsigned i = start; i < start + count; i++)
                if (i >= 2 && !written[i - 2])
                    return 1'b0;
            return 1'b1;
        endfunction

        function void push_reply(logic st, logic [7:0] data, t4t_pkg::code_t code, logic fin,
                                 logic whole);
            t4t_pkg::out_item_t r;
            r.is_status       = st;
            r.data_byte       = data;
            r.status_code     = code;
            r.final_piece     = fin;
            r.whole_file_sent = whole;
            due_replies.push_back(r);
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= ERROR_REPORTS)
                $display("%s", msg);
        endfunction

        function void note_request(t4t_pkg::in_item_t t);
            t4t_pkg::code_t code;
            int unsigned    off;
            int unsigned    size;
            int unsigned    count;
            logic           whole;
            case (t.operation)
                t4t_pkg::OP_LOAD:
                begin
                    msg_bytes[t.load_address] = t.load_byte;
                    written[t.load_address]   = 1'b1;
                end
                t4t_pkg::OP_SESSION:
                    open_file = t4t_pkg::SEL_NONE;
                t4t_pkg::OP_COMMAND:
                begin
                    if (t.class_byte == t4t_pkg::CLASS_ISO &&
                        t.instruction == t4t_pkg::INS_SELECT)
                    begin
                        code = t4t_pkg::CODE_FAIL;
                        if (t.param_one == t4t_pkg::SELECT_P1 &&
                            t.param_two == t4t_pkg::SELECT_P2)
                        begin
                            code = t4t_pkg::CODE_NOT_FOUND;
                            if (t.command_data_length == t4t_pkg::SELECT_DLEN &&
                                t.file_id == t4t_pkg::FID_NDEF)
                            begin
                                open_file = t4t_pkg::SEL_NDEF;
                                code = t4t_pkg::CODE_OK;
                            end
                            else if (t.command_data_length == t4t_pkg::SELECT_DLEN &&
                                     t.file_id == t4t_pkg::FID_CC)
                            begin
                                open_file = t4t_pkg::SEL_CC;
                                code = t4t_pkg::CODE_OK;
                            end
                        end
                        push_reply(1'b1, 8'h00, code, 1'b1, 1'b0);
                    end
                    else if (t.class_byte == t4t_pkg::CLASS_ISO &&
                             t.instruction == t4t_pkg::INS_READ)
                    begin
                        if (t.param_one[7] || open_file == t4t_pkg::SEL_NONE)
                            push_reply(1'b1, 8'h00, t4t_pkg::CODE_FAIL, 1'b1, 1'b0);
                        else
                        begin
                            off  = {17'd0, t.param_one[6:0], t.param_two};
                            size = (open_file == t4t_pkg::SEL_CC) ? 15 : msg_length() + 2;
                            if (off >= size)
                                push_reply(1'b1, 8'h00, t4t_pkg::CODE_OK, 1'b1, 1'b0);
                            else
                            begin
                                count = size - off;
                                if (t.expected_length != 0 && count > t.expected_length)
                                    count = {15'd0, t.expected_length};
                                if (count > REPLY_CAP)
                                    count = REPLY_CAP;
                                whole = (open_file == t4t_pkg::SEL_NDEF && off + count == size);
                                for (int unsigned i = 0; i < count; i++)
                                    push_reply(1'b0, file_at(open_file, off + i),
                                               t4t_pkg::CODE_OK, 1'b0, whole);
                                push_reply(1'b1, 8'h00, t4t_pkg::CODE_OK, 1'b1, whole);
                            end
                        end
                    end
                    else
                        push_reply(1'b1, 8'h00, t4t_pkg::CODE_FAIL, 1'b1, 1'b0);
                end
                default:
                    ;
            endcase
        endfunction

        function void check_reply(t4t_pkg::out_item_t got);
            t4t_pkg::out_item_t want;
            if (due_replies.size() == 0)
            begin
                report($sformatf("Unexpected reply: st=%0d data=%h code=%0d fin=%0d whole=%0d",
                                 got.is_status, got.data_byte, got.status_code,
                                 got.final_piece, got.whole_file_sent));
                return;
            end
            want = due_replies.pop_front();
            if (got.is_status !== want.is_status || got.data_byte !== want.data_byte ||
                got.status_code !== want.status_code || got.final_piece !== want.final_piece ||
                got.whole_file_sent !== want.whole_file_sent)
                report($sformatf({"Reply mismatch: expected st=%0d data=%h code=%0d fin=%0d ",
                                  "whole=%0d, got st=%0d data=%h code=%0d fin=%0d whole=%0d"},
                                 want.is_status, want.data_byte, want.status_code,
                                 want.final_piece, want.whole_file_sent,
                                 got.is_status, got.data_byte, got.status_code,
                                 got.final_piece, got.whole_file_sent));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [10:0] cfg_wdata;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          cycle_count = 0;

    tag_reply_board board = new();

    t4t_req_if req_ch ();
    t4t_rsp_if rsp_ch ();

    type4_tag_apdu_responder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                board.note_request(req_ch.payload);
            if (rsp_ch.valid && rsp_ch.ready)
                board.check_reply(rsp_ch.payload);
        end
    end

    function automatic t4t_pkg::in_item_t random_fields();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(t4t_pkg::in_item_t)-1:0];
    endfunction

    function automatic t4t_pkg::in_item_t load_item(input logic [9:0] addr,
                                                     input logic [7:0] value);
        t4t_pkg::in_item_t item;
        item = random_fields();
        item.operation    = t4t_pkg::OP_LOAD;
        item.load_address = addr;
        item.load_byte    = value;
        return item;
    endfunction

    function automatic t4t_pkg::in_item_t session_item();
        t4t_pkg::in_item_t item;
        item = random_fields();
        item.operation = t4t_pkg::OP_SESSION;
        return item;
    endfunction

    function automatic t4t_pkg::in_item_t command_item(input logic [7:0] cla,
                                                        input logic [7:0] ins,
                                                        input logic [7:0] p1,
                                                        input logic [7:0] p2,
                                                        input logic [7:0] dlen,
                                                        input logic [15:0] fid,
                                                        input logic [16:0] limit);
        t4t_pkg::in_item_t item;
        item = random_fields();
        item.operation           = t4t_pkg::OP_COMMAND;
        item.class_byte          = cla;
        item.instruction         = ins;
        item.param_one           = p1;
        item.param_two           = p2;
        item.command_data_length = dlen;
        item.file_id             = fid;
        item.expected_length     = limit;
        return item;
    endfunction

    function automatic t4t_pkg::in_item_t select_item(input logic [15:0] fid);
        return command_item(t4t_pkg::CLASS_ISO, t4t_pkg::INS_SELECT, t4t_pkg::SELECT_P1,
                            t4t_pkg::SELECT_P2, t4t_pkg::SELECT_DLEN, fid, 17'($urandom));
    endfunction

    function automatic t4t_pkg::in_item_t read_item(input logic [15:0] off,
                                                     input logic [16:0] limit);
        return command_item(t4t_pkg::CLASS_ISO, t4t_pkg::INS_READ, off[15:8], off[7:0],
                            8'($urandom), 16'($urandom), limit);
    endfunction

    function automatic t4t_pkg::in_item_t random_request();
        t4t_pkg::in_item_t item;
        int unsigned       pick;
        int                span;
        int                near;
        logic [15:0]       off;
        logic [16:0]       limit;
        pick = $urandom_range(99);
        span = int'(board.msg_length()) + 2;
        if (span < 15)
            span = 15;
        case ($urandom_range(9))
            0, 1, 2: limit = '0;
            3, 4, 5: limit = 17'($urandom_range(1, 70));
            6:       limit = 17'($urandom_range(1, 3));
            7:       limit = 17'h10000;
            default: limit = 17'($urandom);
        endcase
        case ($urandom_range(19))
            16, 17:  off = {1'b0, 15'($urandom)};
            18, 19:  off = {1'b1, 15'($urandom)};
            12, 13, 14, 15:
            begin
                near = span - 1 - int'($urandom_range(0, 70));
                off = (near < 0) ? 16'd0 : 16'(near);
            end
            default: off = 16'($urandom_range(0, span + 2));
        endcase
        if (pick < 12)
            item = load_item(10'($urandom), 8'($urandom));
        else if (pick < 17)
            item = session_item();
        else if (pick < 19)
        begin
            item = random_fields();
            item.operation = OP_UNUSED;
        end
        else if (pick < 21)
            item = command_item(8'($urandom_range(1, 255)),
                                pick[0] ? t4t_pkg::INS_SELECT : t4t_pkg::INS_READ,
                                8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                                17'($urandom));
        else if (pick < 23)
            item = command_item(t4t_pkg::CLASS_ISO, 8'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom), 16'($urandom), 17'($urandom));
        else if (pick < 31)
            item = select_item(($urandom_range(3) == 0) ? t4t_pkg::FID_CC : t4t_pkg::FID_NDEF);
        else if (pick < 36)
        begin
            item = select_item(t4t_pkg::FID_NDEF);
            case ($urandom_range(3))
                0:       item.param_one = 8'($urandom_range(1, 255));
                1:       item.param_two = 8'($urandom);
                2:       item.command_data_length = 8'($urandom);
                default: item.file_id = 16'($urandom);
            endcase
        end
        else
        begin
            if (!board.read_is_safe(off, limit))
                off = 16'd0;
            item = read_item(off, limit);
        end
        return item;
    endfunction

    task automatic send_request(input t4t_pkg::in_item_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= item;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.due_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [10:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.length_reg = value;
    endtask

    initial
    begin
        logic [10:0]       length_plan [8];
        t4t_pkg::in_item_t item;
        int                sent;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        length_plan    = '{11'd1024, 11'd2047, 11'd0, 11'd1, 11'd63, 11'd1023, 11'd2, 11'd61};
        length_plan[6] = 11'($urandom_range(2, 1024));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_length(11'd0);
        for (int a = 0; a < HEAD_LOADS; a++)
            send_request(load_item(a[9:0], 8'($urandom)));
        for (int a = STORE_DEPTH - TAIL_LOADS; a < STORE_DEPTH; a++)
            send_request(load_item(a[9:0], 8'($urandom)));

        write_length(11'd20);
        send_request(read_item(16'h0000, 17'd0));
        send_request(select_item(t4t_pkg::FID_CC));
        send_request(read_item(16'h0000, 17'd0));
        send_request(read_item(16'd11, 17'd2));
        send_request(read_item(16'd15, 17'd0));
        send_request(read_item(16'h8000, 17'd0));
        send_request(command_item(t4t_pkg::CLASS_ISO, t4t_pkg::INS_SELECT, 8'h01,
                                  t4t_pkg::SELECT_P2, t4t_pkg::SELECT_DLEN,
                                  t4t_pkg::FID_NDEF, 17'd0));
        send_request(command_item(t4t_pkg::CLASS_ISO, t4t_pkg::INS_SELECT, t4t_pkg::SELECT_P1,
                                  8'h00, t4t_pkg::SELECT_DLEN, t4t_pkg::FID_NDEF, 17'd0));
        send_request(command_item(t4t_pkg::CLASS_ISO, t4t_pkg::INS_SELECT, t4t_pkg::SELECT_P1,
                                  t4t_pkg::SELECT_P2, 8'd3, t4t_pkg::FID_NDEF, 17'd0));
        send_request(command_item(t4t_pkg::CLASS_ISO, t4t_pkg::INS_SELECT, t4t_pkg::SELECT_P1,
                                  t4t_pkg::SELECT_P2, t4t_pkg::SELECT_DLEN, 16'hFFFF, 17'd0));
        send_request(select_item(t4t_pkg::FID_NDEF));
        send_request(read_item(16'h0000, 17'd0));
        send_request(read_item(16'h0000, 17'd5));
        send_request(read_item(16'd17, 17'h10000));
        send_request(read_item(16'h7FFF, 17'h1FFFF));
        send_request(command_item(8'hFF, t4t_pkg::INS_SELECT, t4t_pkg::SELECT_P1,
                                  t4t_pkg::SELECT_P2, t4t_pkg::SELECT_DLEN,
                                  t4t_pkg::FID_NDEF, 17'd0));
        send_request(command_item(t4t_pkg::CLASS_ISO, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000,
                                  17'd0));
        send_request(command_item(t4t_pkg::CLASS_ISO, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF,
                                  17'd0));
        item = random_fields();
        item.operation = OP_UNUSED;
        send_request(item);
        send_request(load_item(10'd1023, 8'hFF));
        send_request(load_item(10'd0, 8'h00));
        send_request(session_item());
        send_request(read_item(16'h0000, 17'd0));
        send_request(select_item(t4t_pkg::FID_NDEF));
        send_request(read_item(16'h0000, 17'd0));

        for (int ph = 0; ph < 8; ph++)
        begin
            write_length(length_plan[ph]);
            case (ph / 2)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 71;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 71;
                end
                default:
                begin
                    send_idle_pct  = 25;
                    recv_stall_pct = 25;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                item = random_request();
                send_request(item);
                sent++;
            end
        end

        settle();
        if (board.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* type4_tag_apdu_responder_core.f */
hw/rtl/t4t_pkg.sv
hw/rtl/t4t_if.sv
hw/rtl/t4t_ctrl.sv
hw/rtl/t4t_datapath.sv
hw/rtl/type4_tag_apdu_responder_core.sv
bench/type4_tag_apdu_responder_core_test.sv
